// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked property check, disabled while reset is asserted
`define HSFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("hsfd assertion failed");
// same check, named for implication style properties
`define HSFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hsfd implication failed");
`else
`define HSFD_ASSERT(lbl, clk, rstn, prop)
`define HSFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/hsfd_pkg.sv =====
// shared types, constants and crc function of the frame decoder
package hsfd_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0]  CrcPoly      = 8'h31;
  localparam logic [7:0]  CrcInit      = 8'hFF;
  localparam logic [7:0]  StatusMask   = 8'hFC;
  localparam logic [14:0] TempSpan     = 15'd17500;
  localparam logic [14:0] HumSpan      = 15'd10000;
  localparam logic [14:0] TempOffset   = 15'd4500;
  localparam logic [16:0] FullScale    = 17'd65535;

  // command from the front to the conversion back end
  typedef struct packed {
    logic        is_hum;
    logic        crc_ok;
    logic        temp_ok;
    logic [15:0] word;
  } conv_cmd_t;

  // one byte through the crc-8, msb first
  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/hsfd_front.sv =====
// byte front end: reply position tracking, crc check, command issue
`include "assert_macros.svh"
module hsfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  input  logic                q_full_i,
  output logic                push_o,
  output hsfd_pkg::conv_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  pos_e       pos_q, pos_d, pos_cur;
  logic [7:0] crc_q, crc_d;
  logic [7:0] hi_q, hi_d;
  logic [7:0] lo_q, lo_d;
  logic       temp_ok_q, temp_ok_d;
  logic       accept;
  logic       crc_match;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign crc_match  = (crc_q == rx_byte_i);
  assign pos_cur    = frame_start_i ? POS_T_HI : pos_q;

  // next state and command for the current byte
  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    temp_ok_d  = temp_ok_q;
    push_o     = 1'b0;
    cmd_o.is_hum  = 1'b0;
    cmd_o.crc_ok  = crc_match;
    cmd_o.temp_ok = temp_ok_q;
    cmd_o.word    = {hi_q, lo_q & hsfd_pkg::StatusMask};
    if (accept) begin
      unique case (pos_cur)
        POS_T_HI, POS_H_HI: begin
          crc_d = hsfd_pkg::crc8_feed(hsfd_pkg::CrcInit, rx_byte_i);
          hi_d  = rx_byte_i;
          pos_d = (pos_cur == POS_T_HI) ? POS_T_LO : POS_H_LO;
        end
        POS_T_LO, POS_H_LO: begin
          crc_d = hsfd_pkg::crc8_feed(crc_q, rx_byte_i);
          lo_d  = rx_byte_i;
          pos_d = (pos_cur == POS_T_LO) ? POS_T_CRC : POS_H_CRC;
        end
        POS_T_CRC: begin
          temp_ok_d = crc_match;
          push_o    = crc_match;
          pos_d     = POS_H_HI;
        end
        POS_H_CRC: begin
          cmd_o.is_hum = 1'b1;
          push_o       = 1'b1;
          pos_d        = POS_T_HI;
        end
        default: begin
          // unreachable positions restart the reply
          crc_d = hsfd_pkg::crc8_feed(hsfd_pkg::CrcInit, rx_byte_i);
          hi_d  = rx_byte_i;
          pos_d = POS_T_LO;
        end
      endcase
    end
  end

  // position and crc state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_T_HI;
      crc_q     <= hsfd_pkg::CrcInit;
      hi_q      <= 8'd0;
      lo_q      <= 8'd0;
      temp_ok_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      temp_ok_q <= temp_ok_d;
    end
  end

  `HSFD_ASSERT_IMPL(a_push_gated, clk_i, rst_ni, push_o, accept)

endmodule

// ===== rtl/hsfd_queue.sv =====
// short command queue between front and back
`include "assert_macros.svh"
module hsfd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hsfd_pkg::conv_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hsfd_pkg::conv_cmd_t pop_data_o
);

  hsfd_pkg::conv_cmd_t            mem_q [hsfd_pkg::QDepth];
  logic [hsfd_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [hsfd_pkg::QCntW-1:0]     count_q;

  assign full_o     = (count_q == hsfd_pkg::QCntW'(hsfd_pkg::QDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `HSFD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= hsfd_pkg::QCntW'(hsfd_pkg::QDepth))
  `HSFD_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o)
  `HSFD_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !full_o)

endmodule

// ===== rtl/hsfd_back.sv =====
// conversion back end: scale multiply, divide by full scale, hold, output
`include "assert_macros.svh"
module hsfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  hsfd_pkg::conv_cmd_t q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [14:0]         temperature_centi_o,
  output logic [13:0]         humidity_centi_o,
  output logic                temp_crc_ok_o,
  output logic                hum_crc_ok_o
);

  logic        adv;
  logic        a_valid_q;
  logic        a_hum_q, a_crc_ok_q, a_temp_ok_q;
  logic [30:0] a_prod_q;
  logic [14:0] span;
  logic [14:0] q0;
  logic [16:0] rem;
  logic [14:0] quot;
  logic [14:0] temp_new;
  logic [14:0] held_temp_q;
  logic [13:0] held_hum_q;
  logic        out_valid_q;
  logic [14:0] out_temp_q;
  logic [13:0] out_hum_q;
  logic        out_tok_q, out_hok_q;

  // the whole back end moves when the output register can take an item
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && q_valid_i;
  assign span  = q_data_i.is_hum ? hsfd_pkg::HumSpan : hsfd_pkg::TempSpan;

  // stage a: scale multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_prod_q    <= 31'(q_data_i.word) * 31'(span);
      a_hum_q     <= q_data_i.is_hum;
      a_crc_ok_q  <= q_data_i.crc_ok;
      a_temp_ok_q <= q_data_i.temp_ok;
    end
  end

  // divide by 2^16-1: fold the high half back in, one correction step
  assign q0       = a_prod_q[30:16];
  assign rem      = {1'b0, a_prod_q[15:0]} + {2'b00, q0};
  assign quot     = q0 + 15'(rem >= hsfd_pkg::FullScale);
  assign temp_new = quot - hsfd_pkg::TempOffset;

  // stage b: held values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_temp_q <= 15'd0;
      held_hum_q  <= 14'd0;
    end else if (adv && a_valid_q) begin
      if (!a_hum_q) begin
        held_temp_q <= temp_new;
      end else if (a_crc_ok_q) begin
        held_hum_q <= quot[13:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= a_valid_q && a_hum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_valid_q && a_hum_q) begin
      out_temp_q <= held_temp_q;
      out_hum_q  <= a_crc_ok_q ? quot[13:0] : held_hum_q;
      out_tok_q  <= a_temp_ok_q;
      out_hok_q  <= a_crc_ok_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = out_temp_q;
  assign humidity_centi_o    = out_hum_q;
  assign temp_crc_ok_o       = out_tok_q;
  assign hum_crc_ok_o        = out_hok_q;

  `HSFD_ASSERT_IMPL(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_q), $past(a_valid_q))
  `HSFD_ASSERT_IMPL(a_hum_bound, clk_i, rst_ni, out_valid_q, out_hum_q <= 14'd10000)

endmodule

// ===== rtl/humidity_sensor_frame_decoder_core.sv =====
// top level of the temperature/humidity reply decoder
// result path: the command of the sixth byte goes through the queue, stage a and the output register
// throughput: one byte per cycle while the command queue is not full; one result per six-byte reply
// the back end stalls only while its output register is held by the sink
// reset (async, active low) clears position, crc, held values and the queue
module humidity_sensor_frame_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic        s_axis_tuser_i,  // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [14:0] temperature_centi, [28:15] humidity_centi, [29] temp_crc_ok,
  // [30] hum_crc_ok, [31] zero
  output logic [31:0] m_axis_tdata_o
);

  hsfd_pkg::conv_cmd_t push_cmd, pop_cmd;
  logic                push, pop, q_full, q_valid;
  logic [14:0]         temp_c;
  logic [13:0]         hum_c;
  logic                tok, hok;

  // byte front end
  hsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .rx_byte_i    (s_axis_tdata_i),
    .frame_start_i(s_axis_tuser_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // command queue
  hsfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_cmd)
  );

  // conversion back end
  hsfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_data_i           (pop_cmd),
    .pop_o              (pop),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .temperature_centi_o(temp_c),
    .humidity_centi_o   (hum_c),
    .temp_crc_ok_o      (tok),
    .hum_crc_ok_o       (hok)
  );

  assign m_axis_tdata_o = {1'b0, hok, tok, hum_c, temp_c};

endmodule

// ===== tb/humidity_sensor_frame_decoder_checker.sv =====
// checker for the reply decoder: predicts each reading and compares it with the output
`timescale 1ns / 100ps

package hsfd_tb_pkg;
  import hsfd_pkg::CrcPoly;
  import hsfd_pkg::CrcInit;

  // one decoded reading as it leaves the block, lowest field last
  typedef struct packed {
    logic        pad;
    logic        hum_ok;
    logic        temp_ok;
    logic [13:0] hum;
    logic [14:0] temp;
  } reading_t;

  // crc-8 over one byte, msb first, no reflection
  function automatic logic [7:0] sensor_crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] acc;
    acc = crc ^ b;
    repeat (8) begin
      acc = acc[7] ? ((acc << 1) ^ CrcPoly) : (acc << 1);
    end
    return acc;
  endfunction

  // crc of a whole word as the sensor sends it
  function automatic logic [7:0] sensor_word_crc(logic [15:0] word);
    return sensor_crc8_step(sensor_crc8_step(CrcInit, word[15:8]), word[7:0]);
  endfunction
endpackage

module humidity_sensor_frame_decoder_checker
  import hsfd_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic        s_axis_tuser_i,  // [0] frame_start
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // [14:0] temperature_centi, [28:15] humidity_centi, [29] temp_crc_ok,
  // [30] hum_crc_ok, [31] zero
  input  logic [31:0] m_axis_tdata_i,
  output int          err_count_o,
  output int          pending_o
);

  // byte slots of the six-byte reply
  localparam logic [2:0] SlotTempHi  = 3'd0;
  localparam logic [2:0] SlotTempLo  = 3'd1;
  localparam logic [2:0] SlotTempCrc = 3'd2;
  localparam logic [2:0] SlotHumHi   = 3'd3;
  localparam logic [2:0] SlotHumLo   = 3'd4;
  localparam logic [2:0] SlotHumCrc  = 3'd5;

  localparam logic [15:0] StatusBitsClear = 16'hFFFC;
  localparam int          TempSpanCenti   = 17500;
  localparam int          TempOffsetCenti = 4500;
  localparam int          HumSpanCenti    = 10000;
  localparam int          RawFullScale    = 65535;

  // decoder state as the predictor sees it
  logic [2:0]  slot_q;
  logic [7:0]  crc_q;
  logic [7:0]  word_hi_q;
  logic [7:0]  word_lo_q;
  logic        temp_ok_q;
  logic [14:0] temp_centi_q;
  logic [13:0] hum_centi_q;

  reading_t readings_due[$];
  int       errors;
  int       pending;

  assign err_count_o = errors;
  assign pending_o   = pending;

  // advance the predictor by one received byte
  task automatic absorb_byte(input logic [7:0] b, input logic sof);
    logic [2:0]  slot;
    logic [15:0] word;
    int          raw;
    int          scaled;
    logic        crc_match;
    reading_t    due;
    slot = sof ? SlotTempHi : slot_q;
    if (slot > SlotHumCrc) slot = SlotTempHi;
    word      = {word_hi_q, word_lo_q} & StatusBitsClear;
    raw       = word;
    crc_match = (crc_q == b);
    slot_q    = slot + 3'd1;
    case (slot)
      SlotTempHi, SlotHumHi: begin
        crc_q     = sensor_crc8_step(hsfd_pkg::CrcInit, b);
        word_hi_q = b;
      end
      SlotTempLo, SlotHumLo: begin
        crc_q     = sensor_crc8_step(crc_q, b);
        word_lo_q = b;
      end
      SlotTempCrc: begin
        temp_ok_q = crc_match;
        if (crc_match) begin
          scaled       = (TempSpanCenti * raw) / RawFullScale - TempOffsetCenti;
          temp_centi_q = scaled[14:0];
        end
      end
      default: begin
        if (crc_match) begin
          scaled      = (HumSpanCenti * raw) / RawFullScale;
          hum_centi_q = scaled[13:0];
        end
        due.pad     = 1'b0;
        due.hum_ok  = crc_match;
        due.temp_ok = temp_ok_q;
        due.hum     = hum_centi_q;
        due.temp    = temp_centi_q;
        readings_due.push_back(due);
        slot_q = SlotTempHi;
      end
    endcase
  endtask

  // compare one accepted reading with the oldest one due
  task automatic compare_reading(input reading_t got);
    reading_t want;
    if (readings_due.size() == 0) begin
      $error("reading with none due: %h", got);
      errors++;
    end else begin
      want = readings_due.pop_front();
      if (got.temp !== want.temp) begin
        $error("temperature_centi: expected %0d, actual %0d",
               $signed(want.temp), $signed(got.temp));
        errors++;
      end
      if (got.hum !== want.hum) begin
        $error("humidity_centi: expected %0d, actual %0d", want.hum, got.hum);
        errors++;
      end
      if (got.temp_ok !== want.temp_ok) begin
        $error("temp_crc_ok: expected %0b, actual %0b", want.temp_ok, got.temp_ok);
        errors++;
      end
      if (got.hum_ok !== want.hum_ok) begin
        $error("hum_crc_ok: expected %0b, actual %0b", want.hum_ok, got.hum_ok);
        errors++;
      end
      if (got.pad !== want.pad) begin
        $error("pad bit: expected %0b, actual %0b", want.pad, got.pad);
        errors++;
      end
    end
  endtask

  // watch both channels at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       = SlotTempHi;
      crc_q        = hsfd_pkg::CrcInit;
      word_hi_q    = 8'h00;
      word_lo_q    = 8'h00;
      temp_ok_q    = 1'b0;
      temp_centi_q = '0;
      hum_centi_q  = '0;
      readings_due.delete();
      pending      = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) absorb_byte(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_i && m_axis_tready_i) compare_reading(m_axis_tdata_i);
      pending = readings_due.size();
    end
  end

  initial errors = 0;

endmodule

// ===== tb/testbench.sv =====
// top of the reply decoder testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import hsfd_tb_pkg::*;

  localparam int TargetItems = 1550;
  localparam int DrainEvery  = 250;
  localparam int MaxGap      = 13;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  int          err_count;
  int          pending;

  int   items_sent = 0;
  logic calm = 1'b0;
  logic aligned = 1'b1;

  humidity_sensor_frame_decoder_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  humidity_sensor_frame_decoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .err_count_o     (err_count),
    .pending_o       (pending)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= sof;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // send the first n_bytes of a reply, bad crcs flipped by a nonzero pattern
  task automatic send_reply(input logic [15:0] t_word, input logic [15:0] h_word,
                            input logic t_good, input logic h_good, input logic sof,
                            input int n_bytes);
    logic [7:0] bytes [6];
    bytes[0] = t_word[15:8];
    bytes[1] = t_word[7:0];
    bytes[2] = sensor_word_crc(t_word) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
    bytes[3] = h_word[15:8];
    bytes[4] = h_word[7:0];
    bytes[5] = sensor_word_crc(h_word) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
    for (int i = 0; i < n_bytes; i++) send_byte(bytes[i], (i == 0) ? sof : 1'b0);
  endtask

  // hold off until every due reading has come out
  task automatic drain_readings();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // word values with extra weight on the ends of the range
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0003 | 16'($urandom_range(0, 3) << 14);
      default: return 16'($urandom);
    endcase
  endfunction

  // result sink with random stalls
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
    end
  end

  // reset, directed replies, random traffic, verdict
  initial begin
    int next_drain;
    int kind;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no good value yet: both crcs fail, held values stay zero
    send_reply(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
    // lowest and highest words
    send_reply(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 6);
    send_reply(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
    // partial reply dropped by a fresh frame start
    send_reply(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 2);
    send_reply(16'h8003, 16'h7FFC, 1'b1, 1'b0, 1'b1, 6);
    drain_readings();

    // random traffic: mostly well-formed replies, some noise and cut replies
    next_drain = items_sent + DrainEvery;
    while (items_sent < TargetItems) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        send_reply(pick_word(), pick_word(), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 3) != 0, aligned ? 1'($urandom) : 1'b1, 6);
        aligned = 1'b1;
      end else if (kind < 18) begin
        send_reply(pick_word(), pick_word(), 1'($urandom), 1'($urandom), 1'b1,
                   $urandom_range(1, 5));
        aligned = 1'b0;
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'($urandom));
        aligned = 1'b0;
      end
      if (items_sent >= next_drain) begin
        drain_readings();
        next_drain += DrainEvery;
      end
    end

    drain_readings();
    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hsfd_pkg.sv
rtl/hsfd_front.sv
rtl/hsfd_queue.sv
rtl/hsfd_back.sv
rtl/humidity_sensor_frame_decoder_core.sv
tb/humidity_sensor_frame_decoder_checker.sv
tb/testbench.sv
